>>> src/tzwl_pkg.sv
`default_nettype none

package tzwl_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ID_BITS = 16;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    K_PUSH_ACT = 3'd0,
    K_PUSH_OLD = 3'd1,
    K_POP_OLD  = 3'd2,
    K_FETCH    = 3'd3,
    K_RETIRE   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e             op;
    logic [CNT_W-1:0]     pos;
    logic [ID_BITS-1:0]   new_id;
    logic                 fetch_en;
    logic                 pop_en;
    logic [CNT_W-1:0]     pop_pos;
    logic [CNT_W-1:0]     count;
    logic [CNT_W-1:0]     active;
  } cell_ctrl_t;

  // rippled from cell to cell, front to back
  typedef struct packed {
    logic                 found;
    logic                 hit_act;
    logic [ID_BITS-1:0]   res;
  } cell_chain_t;

endpackage

`default_nettype wire

>>> src/tzwl_cell.sv
`default_nettype none

module tzwl_cell
  import tzwl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [IDX_W-1:0]   idx_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic [ID_BITS-1:0] left_id_i,
  input  wire logic [ID_BITS-1:0] right_id_i,
  input  wire cell_chain_t        chain_i,
  output      logic [ID_BITS-1:0] id_o,
  output      cell_chain_t        chain_o
);

  logic [ID_BITS-1:0] id_q, id_d;
  logic [CNT_W-1:0]   pos_here;
  logic               valid, match, here, pick;

  assign pos_here = CNT_W'(idx_i);
  assign valid    = pos_here < ctrl_i.count;
  assign match    = ctrl_i.fetch_en && valid && (id_q == ctrl_i.new_id);
  assign here     = match && !chain_i.found;
  assign pick     = here || (ctrl_i.pop_en && (pos_here == ctrl_i.pop_pos));

  assign chain_o.found   = chain_i.found | match;
  assign chain_o.hit_act = chain_i.hit_act | (here && (pos_here < ctrl_i.active));
  assign chain_o.res     = chain_i.res | (pick ? id_q : '0);
  assign id_o            = id_q;

  always_comb begin
    id_d = id_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (pos_here == ctrl_i.pos) begin
          id_d = ctrl_i.new_id;
        end else if (pos_here > ctrl_i.pos) begin
          id_d = left_id_i;
        end
      end
      OP_REMOVE: begin
        if (chain_o.found) begin
          id_d = right_id_i;
        end
      end
      default: id_d = id_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

`default_nettype wire

>>> src/two_zone_wait_list.sv
// Channel  Dir  Signals          Contents (low bit up)
// s_axis   in   tuser[2:0]       kind
//               tdata[15:0]      thread_id
// m_axis   out  tuser[1:0]       status
//               tdata[25:0]      result_id, total_count, active_count
//
// One transfer in each cycle: the row of cells shifts, inserts, compacts and
// searches within the cycle of acceptance, and the result sits in an output
// register from the next cycle on. The search ripples through all DEPTH cells.
// Reset clears both counts; cell contents stay undefined until written.
// A stalled result holds its register and blocks input until taken.
`default_nettype none

module two_zone_wait_list
  import tzwl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // thread_id
  input  wire logic [2:0]  s_axis_tuser,  // kind
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,  // result_id, total_count, active_count
  output      logic [1:0]  m_axis_tuser   // status
);

  logic [CNT_W-1:0]   count_q, count_d, active_q, active_d;
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [15:0]        res_q, res_d;
  logic [CNT_W-1:0]   out_total_q, out_active_q;
  logic               accept, full;
  cell_ctrl_t         ctrl;
  kind_e              kind;

  logic [ID_BITS-1:0] ids   [DEPTH];
  cell_chain_t        chain [DEPTH+1];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = count_q == CNT_W'(DEPTH);
  assign kind          = kind_e'(s_axis_tuser);

  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.pos      = '0;
    ctrl.new_id   = ID_BITS'(s_axis_tdata);
    ctrl.fetch_en = 1'b0;
    ctrl.pop_en   = 1'b0;
    ctrl.pop_pos  = count_q - CNT_W'(1);
    ctrl.count    = count_q;
    ctrl.active   = active_q;
    count_d       = count_q;
    active_d      = active_q;
    status_d      = ST_DONE;
    case (kind)
      K_PUSH_ACT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.op  = accept ? OP_INSERT : OP_HOLD;
          count_d  = count_q + CNT_W'(1);
          active_d = active_q + CNT_W'(1);
        end
      end
      K_PUSH_OLD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.op  = accept ? OP_INSERT : OP_HOLD;
          ctrl.pos = active_q;
          count_d  = count_q + CNT_W'(1);
        end
      end
      K_POP_OLD: begin
        if (count_q > active_q) begin
          ctrl.pop_en = 1'b1;
          count_d     = count_q - CNT_W'(1);
        end else begin
          status_d = ST_MISS;
        end
      end
      K_FETCH: begin
        ctrl.fetch_en = 1'b1;
        ctrl.op       = accept ? OP_REMOVE : OP_HOLD;
        if (chain[DEPTH].found) begin
          count_d  = count_q - CNT_W'(1);
          active_d = active_q - CNT_W'(chain[DEPTH].hit_act);
        end else begin
          status_d = ST_MISS;
        end
      end
      K_RETIRE: active_d = '0;
      default: ;
    endcase
    res_d = 16'(chain[DEPTH].res);
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] left_id, right_id;
    if (g == 0) begin : g_first
      assign left_id = ctrl.new_id;
    end else begin : g_mid
      assign left_id = ids[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_id = ids[g];
    end else begin : g_inner
      assign right_id = ids[g+1];
    end
    tzwl_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (IDX_W'(g)),
      .ctrl_i     (ctrl),
      .left_id_i  (left_id),
      .right_id_i (right_id),
      .chain_i    (chain[g]),
      .id_o       (ids[g]),
      .chain_o    (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        active_q    <= active_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      res_q        <= res_d;
      out_total_q  <= count_d;
      out_active_q <= active_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {6'd0, 5'(out_active_q), 5'(out_total_q), res_q};

  a_zones_nested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= count_q)
    else $error("active zone larger than list");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list count beyond depth");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_FULL) |-> (out_total_q == CNT_W'(DEPTH)))
    else $error("insert refused while list not full");

  a_miss_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_DONE) |-> (res_q == '0))
    else $error("id returned on failed operation");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
                || (count_q == $past(count_q) - CNT_W'(1))))
    else $error("list count moved by more than one");

endmodule

`default_nettype wire
